FILE: src/dvbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dvbm_pkg;

  localparam int unsigned VAL_W   = 40;
  localparam int unsigned QUERY_W = 32;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned DOM_W   = 6;

  localparam logic [VAL_W-1:0]   VAL_MAX    = {VAL_W{1'b1}};
  localparam logic [7:0]         ESC_BYTE   = 8'd255;
  localparam logic [VAL_W-1:0]   ESC_BASE   = 40'd254;
  localparam int unsigned        MORE_BIT   = 7;
  localparam logic [SHIFT_W-1:0] SHIFT_STEP = 6'd7;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 6'd63;
  localparam logic [SHIFT_W-1:0] SHIFT_SAT  = 6'd40;
  localparam logic [DOM_W-1:0]   DOM_FULL   = 6'd32;
  localparam logic [DOM_W-1:0]   DOM_RESET  = 6'd24;

  localparam logic FMT_VARINT = 1'b0;
  localparam logic FMT_PLUS   = 1'b1;

  localparam logic REG_GAP_FORMAT  = 1'b0;
  localparam logic REG_DOMAIN_BITS = 1'b1;

  typedef struct packed {
    logic valid;
    logic member;
  } res_t;

endpackage
`default_nettype wire

FILE: src/dvbm_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module dvbm_decode (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [7:0]                     code_byte,
  input  wire logic [dvbm_pkg::QUERY_W-1:0]   query_position,
  input  wire logic                           first_byte,
  input  wire logic                           last_byte,
  input  wire logic                           gap_format,
  input  wire logic [dvbm_pkg::DOM_W-1:0]     domain_bits,
  output dvbm_pkg::res_t                      res
);

  logic [dvbm_pkg::VAL_W-1:0]   running_position, running_position_next;
  logic [dvbm_pkg::VAL_W-1:0]   gap_accumulator, gap_accumulator_next;
  logic [dvbm_pkg::SHIFT_W-1:0] digit_shift, digit_shift_next;
  logic                         escape_seen, escape_seen_next;
  logic                         decided, decided_next;
  logic [dvbm_pkg::QUERY_W-1:0] held_query, held_query_next;

  always_comb begin
    logic [6:0]                   digit;
    logic [47:0]                  dsum;
    logic [dvbm_pkg::VAL_W:0]     psum;
    logic [dvbm_pkg::VAL_W-1:0]   pos;
    logic [dvbm_pkg::VAL_W-1:0]   hq_ext;
    logic                         done;
    logic                         out_of_domain;

    running_position_next = running_position;
    gap_accumulator_next  = gap_accumulator;
    digit_shift_next      = digit_shift;
    escape_seen_next      = escape_seen;
    decided_next          = decided;
    held_query_next       = held_query;
    res                   = '0;
    digit                 = code_byte[6:0];
    dsum                  = '0;
    psum                  = '0;
    pos                   = '0;
    done                  = 1'b0;
    out_of_domain         = 1'b0;

    if (first_byte) begin
      running_position_next = '0;
      gap_accumulator_next  = '0;
      digit_shift_next      = '0;
      escape_seen_next      = 1'b0;
      decided_next          = 1'b0;
      held_query_next       = query_position;
      if (domain_bits < dvbm_pkg::DOM_FULL &&
          (query_position >> domain_bits[4:0]) != '0) begin
        out_of_domain = 1'b1;
        decided_next  = 1'b1;
        res.valid     = 1'b1;
        res.member    = 1'b0;
      end
    end
    hq_ext = {{(dvbm_pkg::VAL_W-dvbm_pkg::QUERY_W){1'b0}}, held_query_next};

    if (!out_of_domain && !decided_next) begin
      if (gap_format == dvbm_pkg::FMT_PLUS && !escape_seen_next) begin
        if (code_byte == dvbm_pkg::ESC_BYTE) begin
          escape_seen_next     = 1'b1;
          gap_accumulator_next = dvbm_pkg::ESC_BASE;
          digit_shift_next     = '0;
        end else begin
          gap_accumulator_next = {32'd0, code_byte};
          done                 = 1'b1;
        end
      end else begin
        // one base-128 digit
        if (digit != '0) begin
          if (digit_shift_next >= dvbm_pkg::SHIFT_SAT) begin
            gap_accumulator_next = dvbm_pkg::VAL_MAX;
          end else begin
            dsum = {8'd0, gap_accumulator_next} + ({41'd0, digit} << digit_shift_next);
            gap_accumulator_next = (dsum[47:40] != '0) ? dvbm_pkg::VAL_MAX : dsum[39:0];
          end
        end
        if (code_byte[dvbm_pkg::MORE_BIT]) begin
          digit_shift_next = (digit_shift_next > dvbm_pkg::SHIFT_MAX - dvbm_pkg::SHIFT_STEP) ?
                             dvbm_pkg::SHIFT_MAX : digit_shift_next + dvbm_pkg::SHIFT_STEP;
        end else begin
          done = 1'b1;
        end
      end

      if (done) begin
        psum = {1'b0, running_position_next} + {1'b0, gap_accumulator_next};
        pos  = psum[dvbm_pkg::VAL_W] ? dvbm_pkg::VAL_MAX : psum[dvbm_pkg::VAL_W-1:0];
        gap_accumulator_next = '0;
        digit_shift_next     = '0;
        escape_seen_next     = 1'b0;
        if (pos == hq_ext) begin
          decided_next = 1'b1;
          res.valid    = 1'b1;
          res.member   = 1'b1;
        end else if (pos > hq_ext) begin
          decided_next = 1'b1;
          res.valid    = 1'b1;
          res.member   = 1'b0;
        end else begin
          running_position_next = pos;
        end
      end

      if (last_byte && !res.valid) begin
        decided_next = 1'b1;
        res.valid    = 1'b1;
        res.member   = 1'b0;
      end
    end

    if (!accept) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_position <= '0;
      gap_accumulator  <= '0;
      digit_shift      <= '0;
      escape_seen      <= 1'b0;
      decided          <= 1'b1;
      held_query       <= '0;
    end else if (accept) begin
      running_position <= running_position_next;
      gap_accumulator  <= gap_accumulator_next;
      digit_shift      <= digit_shift_next;
      escape_seen      <= escape_seen_next;
      decided          <= decided_next;
      held_query       <= held_query_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/delta_varint_bitmap_membership_test.sv
// The answer to a stream is written into the result queue at the edge that accepts the byte that decides it.
// Throughput: one code byte per cycle; each byte is decoded in one pass of the
// shift-add-compare logic between the state registers and a two-deep result queue.
// Bytes are stalled only while both queue entries hold untaken results.
// Reset: synchronous; decoder idles until a first byte, gap_format = 0, domain_bits = 24.
`timescale 1ns / 1ps
`default_nettype none
module delta_varint_bitmap_membership_test (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic                                 cfg_index,
  input  wire logic [dvbm_pkg::DOM_W-1:0]           cfg_data,
  input  wire logic                                 byte_valid,
  output logic                                      byte_stall,
  input  wire logic [7:0]                           code_byte,
  input  wire logic [dvbm_pkg::QUERY_W-1:0]         query_position,
  input  wire logic                                 first_byte,
  input  wire logic                                 last_byte,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic                                      is_member
);

  logic                          gap_format;
  logic [dvbm_pkg::DOM_W-1:0]    domain_bits;
  logic                          accept;
  dvbm_pkg::res_t                res;

  logic [1:0] queue;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_format  <= dvbm_pkg::FMT_VARINT;
      domain_bits <= dvbm_pkg::DOM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dvbm_pkg::REG_GAP_FORMAT:  gap_format  <= cfg_data[0];
        dvbm_pkg::REG_DOMAIN_BITS: domain_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  assign byte_stall = count[1];
  assign accept     = byte_valid && !byte_stall;

  dvbm_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .code_byte      (code_byte),
    .query_position (query_position),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .gap_format     (gap_format),
    .domain_bits    (domain_bits),
    .res            (res)
  );

  // two-entry result queue
  assign push         = res.valid;
  assign pop          = result_valid && !result_stall;
  assign result_valid = count != 2'd0;
  assign is_member    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= res.member;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/delta_varint_bitmap_membership_test_test.sv
`timescale 1ns / 1ps
module delta_varint_bitmap_membership_test_test;

  localparam int unsigned RANDOM_ITEMS  = 520;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = dvbm_pkg::REG_GAP_FORMAT;
  logic [5:0]  cfg_data = '0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  code_byte = '0;
  logic [31:0] query_position = '0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        is_member;

  // decoder shadow state
  logic        fmt_plus;
  logic [5:0]  dom_width;
  logic [39:0] pos_acc;
  logic [39:0] gap_acc;
  logic [5:0]  shift_at;
  logic        in_escape;
  logic        answered;
  logic [31:0] query_held;
  logic        expected_member[$];

  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  delta_varint_bitmap_membership_test u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .code_byte      (code_byte),
    .query_position (query_position),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .is_member      (is_member)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pause_len(input bit enabled);
    return enabled ? $urandom_range(0, 9) : 0;
  endfunction

  function automatic logic [39:0] sat40(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(dvbm_pkg::VAL_MAX)) ? dvbm_pkg::VAL_MAX : s[39:0];
  endfunction

  // one base-128 digit; returns 1 when the gap is complete
  function automatic bit take_digit(input logic [7:0] b);
    logic [63:0] part;
    if (b[6:0] != 7'd0) begin
      if (shift_at >= dvbm_pkg::SHIFT_SAT) begin
        gap_acc = dvbm_pkg::VAL_MAX;
      end else begin
        part = 64'(b[6:0]) << shift_at;
        gap_acc = sat40(64'(gap_acc), part);
      end
    end
    if (b[dvbm_pkg::MORE_BIT]) begin
      shift_at = (shift_at > dvbm_pkg::SHIFT_MAX - dvbm_pkg::SHIFT_STEP) ?
                 dvbm_pkg::SHIFT_MAX : shift_at + dvbm_pkg::SHIFT_STEP;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic [31:0] q,
                                      input logic f, input logic l);
    bit          complete;
    logic [39:0] next_pos;
    if (f) begin
      pos_acc = '0;
      gap_acc = '0;
      shift_at = '0;
      in_escape = 1'b0;
      answered = 1'b0;
      query_held = q;
      if (dom_width < dvbm_pkg::DOM_FULL && (q >> dom_width) != 32'd0) begin
        answered = 1'b1;
        expected_member = {expected_member, 1'b0};
        return;
      end
    end
    if (answered) return;
    if (fmt_plus == dvbm_pkg::FMT_VARINT) begin
      complete = take_digit(b);
    end else if (!in_escape) begin
      if (b == dvbm_pkg::ESC_BYTE) begin
        in_escape = 1'b1;
        gap_acc = dvbm_pkg::ESC_BASE;
        shift_at = '0;
        complete = 1'b0;
      end else begin
        gap_acc = 40'(b);
        complete = 1'b1;
      end
    end else begin
      complete = take_digit(b);
    end
    if (complete) begin
      next_pos = sat40(64'(pos_acc), 64'(gap_acc));
      gap_acc = '0;
      shift_at = '0;
      in_escape = 1'b0;
      if (next_pos == 40'(query_held)) begin
        answered = 1'b1;
        expected_member = {expected_member, 1'b1};
        return;
      end
      if (next_pos > 40'(query_held)) begin
        answered = 1'b1;
        expected_member = {expected_member, 1'b0};
        return;
      end
      pos_acc = next_pos;
    end
    if (l) begin
      answered = 1'b1;
      expected_member = {expected_member, 1'b0};
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // called and returns at a rising edge; returns at the edge that takes the request
  task automatic send_byte(input logic [7:0] b, input logic [31:0] q,
                           input logic f, input logic l);
    int unsigned idle;
    idle = pause_len(sender_idles);
    if (idle != 0) begin
      byte_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    byte_valid     <= 1'b1;
    code_byte      <= b;
    query_position <= q;
    first_byte     <= f;
    last_byte      <= l;
    do @(posedge clk); while (byte_stall);
    decode_byte(b, q, f, l);
  endtask

  task automatic send_stream(input logic [7:0] bytes[$], input logic [31:0] query,
                             input bit mark_last);
    foreach (bytes[i]) begin
      send_byte(bytes[i], (i == 0) ? query : $urandom(), i == 0,
                mark_last && (i == bytes.size() - 1));
    end
  endtask

  // hold off requests until every answer is in, then let the decoder go quiet
  task automatic settle();
    byte_valid <= 1'b0;
    while (expected_member.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic fmt, input logic [5:0] dom);
    cfg_write <= 1'b1;
    cfg_index <= dvbm_pkg::REG_GAP_FORMAT;
    cfg_data  <= {5'($urandom()), fmt};
    @(posedge clk);
    cfg_index <= dvbm_pkg::REG_DOMAIN_BITS;
    cfg_data  <= dom;
    @(posedge clk);
    cfg_write <= 1'b0;
    fmt_plus  = fmt;
    dom_width = dom;
  endtask

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (result_valid && !result_stall) begin
      if (expected_member.size() == 0) begin
        report_mismatch($sformatf("answer is_member=%0b with none pending", is_member));
      end else begin
        want = expected_member.pop_front();
        if (is_member !== want)
          report_mismatch($sformatf("is_member=%0b, predicted %0b", is_member, want));
      end
      stall_left = pause_len(receiver_idles);
      result_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (result_valid && !result_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_idle_bytes();
    // decoder idles after reset: nothing comes back, even on a last byte
    send_byte(8'h05, $urandom(), 1'b0, 1'b0);
    send_byte(8'hFF, $urandom(), 1'b0, 1'b1);
  endtask

  task automatic test_plain_gaps();
    send_stream('{8'd3, 8'd2}, 32'd5, 1'b1);
    send_stream('{8'hAC, 8'h02}, 32'd300, 1'b1);
    send_stream('{8'h01}, 32'd1000, 1'b1);
    send_stream('{8'h00}, 32'd0, 1'b1);
  endtask

  task automatic test_query_domain();
    send_stream('{8'd3, 8'd4}, 32'd1 << 24, 1'b1);
    settle();
    program_regs(dvbm_pkg::FMT_VARINT, 6'd8);
    send_stream('{8'h01}, 32'd256, 1'b1);
    send_stream('{8'hFF, 8'h01}, 32'd255, 1'b1);
  endtask

  task automatic test_saturation();
    settle();
    program_regs(dvbm_pkg::FMT_VARINT, dvbm_pkg::DOM_FULL);
    send_stream('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01}, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_plus_gaps();
    settle();
    program_regs(dvbm_pkg::FMT_PLUS, dvbm_pkg::DOM_FULL);
    send_stream('{8'd10, 8'hFF, 8'h05}, 32'd269, 1'b1);
    send_stream('{8'd254}, 32'd254, 1'b1);
  endtask

  task automatic test_format_switch();
    // escape opened in plus format, gap finished as a plain varint
    send_byte(8'hFF, 32'd1000, 1'b1, 1'b0);
    settle();
    program_regs(dvbm_pkg::FMT_VARINT, dvbm_pkg::DOM_FULL);
    send_byte(8'h81, $urandom(), 1'b0, 1'b0);
    send_byte(8'h01, $urandom(), 1'b0, 1'b0);
    settle();
    program_regs(dvbm_pkg::FMT_PLUS, dvbm_pkg::DOM_FULL);
    send_byte(8'hFF, $urandom(), 1'b0, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [7:0]  bytes[$];
    logic [39:0] points[$];
    logic [63:0] gap;
    logic [63:0] v;
    logic [63:0] pos;
    logic [7:0]  digit;
    logic [31:0] query;
    logic [5:0]  dom;
    int unsigned sent;
    int unsigned phase_end;
    int unsigned pick;
    int unsigned idx;
    int unsigned keep;
    bit          mark_last;
    bit          escaped;
    sent = 0;
    phase_end = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= phase_end) begin
        settle();
        case ($urandom_range(0, 5))
          0:       dom = 6'd8;
          1:       dom = dvbm_pkg::DOM_FULL;
          2:       dom = dvbm_pkg::DOM_RESET;
          3:       dom = 6'd31;
          default: dom = 6'($urandom_range(8, 32));
        endcase
        program_regs(1'($urandom_range(0, 1)), dom);
        sender_idles   = ($urandom_range(0, 2) != 0);
        receiver_idles = ($urandom_range(0, 2) != 0);
        phase_end = sent + $urandom_range(60, 120);
      end
      bytes.delete();
      points.delete();
      pos = '0;
      mark_last = 1'b1;
      pick = $urandom_range(0, 13);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) bytes = {bytes, 8'($urandom())};
        query = $urandom();
        mark_last = 1'($urandom_range(0, 1));
      end else if (pick == 1) begin
        // long run of empty digits drives the shift past its saturation point
        repeat ($urandom_range(6, 11)) bytes = {bytes, 8'h80};
        bytes = {bytes, 8'($urandom_range(0, 127))};
        query = $urandom();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 9))
            0:             gap = 64'd0;
            1, 2, 3, 4:    gap = 64'($urandom_range(1, 127));
            5, 6:          gap = 64'($urandom_range(128, 20000));
            7:             gap = 64'($urandom_range(252, 258));
            8:             gap = 64'($urandom_range(0, 1 << 20));
            default:       gap = {$urandom(), $urandom()} >> $urandom_range(24, 40);
          endcase
          pos = 64'(sat40(pos, gap));
          points = {points, pos[39:0]};
          escaped = (fmt_plus == dvbm_pkg::FMT_PLUS) &&
                    (gap > 64'd254 || (gap == 64'd254 && $urandom_range(0, 1) == 1));
          if (fmt_plus == dvbm_pkg::FMT_PLUS && !escaped) begin
            bytes = {bytes, gap[7:0]};
          end else begin
            if (escaped) begin
              bytes = {bytes, dvbm_pkg::ESC_BYTE};
              v = gap - 64'd254;
            end else begin
              v = gap;
            end
            do begin
              digit = {1'b0, v[6:0]};
              v = v >> 7;
              if (v != 0) digit[7] = 1'b1;
              bytes = {bytes, digit};
            end while (v != 0);
            if ($urandom_range(0, 7) == 0) begin
              bytes[bytes.size() - 1][7] = 1'b1;
              bytes = {bytes, 8'h00};
            end
          end
        end
        idx = $urandom_range(0, points.size() - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: query = points[idx][31:0];
          5:             query = points[idx][31:0] + 32'd1;
          6:             query = points[idx][31:0] - 32'd1;
          7:             query = $urandom() & ((32'd1 << dom_width) - 32'd1);
          8:             query = $urandom();
          default:       query = (32'd1 << dom_width) - 32'($urandom_range(0, 1));
        endcase
        if (pick == 2 || pick == 3) begin
          keep = $urandom_range(1, bytes.size());
          while (bytes.size() > keep) void'(bytes.pop_back());
          mark_last = (pick == 3);
        end
      end
      send_stream(bytes, query, mark_last);
      sent += bytes.size();
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom()), $urandom(), 1'b0, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 29) == 0) settle();
    end
  endtask

  initial begin
    fmt_plus   = dvbm_pkg::FMT_VARINT;
    dom_width  = dvbm_pkg::DOM_RESET;
    pos_acc    = '0;
    gap_acc    = '0;
    shift_at   = '0;
    in_escape  = 1'b0;
    answered   = 1'b1;
    query_held = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_plain_gaps();
    test_query_domain();
    test_saturation();
    test_plus_gaps();
    test_format_switch();
    test_random_streams();
    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
